FILE: sv/fptk_pkg.sv
// Shared package of the fixed-point track filter: payload words, operation and
// register codes, reset values and the saturating arithmetic helpers.
// No dependencies.
package fptk_pkg;

	// Fixed-point scale of velocities and covariance entries. It must be a power of two.
	localparam int UNIT = 256;
	localparam int UNIT_LOG2 = $clog2(UNIT);
	localparam int HALF_UNIT = UNIT / 2;

	localparam int NUM_TRACKS_DEF = 16;
	localparam int TRACK_W = 4;
	localparam int DIV_W = 64;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] FUNC_PREDICT = 2'd0;
	localparam logic [1:0] FUNC_CORRECT = 2'd1;
	localparam logic [1:0] FUNC_INIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PNOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MNOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE = 2'd2;

	localparam logic [15:0] PNOISE_RST = 16'd256;
	localparam logic [15:0] MNOISE_RST = 16'd25;
	localparam logic [7:0] EXPIRE_RST = 8'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [TRACK_W-1:0] track;
		logic signed [15:0] meas_x;
		logic signed [15:0] meas_y;
	} req_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic live;
		logic expired;
		logic singular;
		logic [15:0] age_out;
		logic [7:0] missed_out;
		logic [15:0] seen_out;
	} rsp_t;

	// Per-track record kept in one memory word.
	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [15:0] age;
		logic [7:0] missed;
		logic [15:0] seen;
	} rec_t;

	// Saturate a 65-bit sum or difference to 64 bits.
	function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
		logic signed [63:0] r;
		if (v[64] != v[63]) begin
			r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r = v[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] c32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -66'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] c16(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sh7FFF) begin
			r = 16'sh7FFF;
		end else if (v < -34'sh8000) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Limit of the position step taken in one correction.
	function automatic logic signed [17:0] clamp_step(input logic signed [63:0] v);
		logic signed [17:0] r;
		if (v > 64'sd70000) begin
			r = 18'sd70000;
		end else if (v < -64'sd70000) begin
			r = -18'sd70000;
		end else begin
			r = v[17:0];
		end
		return r;
	endfunction

	// Division by UNIT, truncating toward zero.
	function automatic logic signed [63:0] trunc_unit(input logic signed [63:0] x);
		logic signed [63:0] b;
		b = x + (x[63] ? $signed(64'(UNIT - 1)) : 64'sd0);
		return b >>> UNIT_LOG2;
	endfunction

endpackage

FILE: sv/fptk_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module fptk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/fptk_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on fptk_pkg.
module fptk_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [fptk_pkg::DIV_W-1:0] num,
	input logic signed [fptk_pkg::DIV_W-1:0] den,
	output logic busy,
	output logic done,
	output logic signed [fptk_pkg::DIV_W:0] quot
);
	import fptk_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [DIV_W:0] shifted, diff;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[DIV_W-1] ? DIV_W'(-num) : num;
			den_q <= den[DIV_W-1] ? DIV_W'(-den) : den;
			rem_q <= '0;
			neg_q <= num[DIV_W-1] ^ den[DIV_W-1];
		end else if (busy_q) begin
			rem_q <= diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ~diff[DIV_W]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

FILE: sv/fixed_point_track_kalman_top.sv
// Table of 2-D constant-velocity tracks with a fixed-point Kalman predict and correct.
// Correct takes the longest of the operations: its eight gain divisions in the shared
// divider dominate it. An index beyond the table skips the track work. One word is
// worked on at a time; a new word is taken only once the last one's response is registered.
// Reset clears all tracks to zero and invalid and loads register defaults.
module fixed_point_track_kalman_top #(
	parameter int NUM_TRACKS = fptk_pkg::NUM_TRACKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input fptk_pkg::req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output fptk_pkg::rsp_t rsp_data,
	input logic cfg_we,
	input logic [fptk_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fptk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fptk_pkg::*;

	localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int COV_DEPTH = NUM_TRACKS * 16;
	localparam logic signed [63:0] HALF_S64 = 64'(HALF_UNIT);
	localparam logic signed [33:0] UNIT_S34 = 34'(UNIT);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_EXEC = 4'd2;
	localparam logic [3:0] ST_ZERO = 4'd3;
	localparam logic [3:0] ST_PWR = 4'd4;
	localparam logic [3:0] ST_DET = 4'd5;
	localparam logic [3:0] ST_GAIN = 4'd6;
	localparam logic [3:0] ST_DIVW = 4'd7;
	localparam logic [3:0] ST_UPD = 4'd8;
	localparam logic [3:0] ST_COV = 4'd9;
	localparam logic [3:0] ST_WB = 4'd10;
	localparam logic [3:0] ST_FIN = 4'd11;

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] ph_q;
	logic [NUM_TRACKS-1:0] valid_q, wr_q;
	logic out_valid_q;
	logic [15:0] pnoise_q, mnoise_q;
	logic [7:0] elim_q;

	logic [1:0] func_q;
	logic [TRACK_W-1:0] trk_q;
	logic signed [15:0] mx_q, my_q;
	logic range_ok_q, expired_q, singular_q;
	logic signed [31:0] cov_q [16];
	logic signed [31:0] g_q [8];
	logic signed [33:0] s00_q, s01_q, s10_q, s11_q;
	logic signed [16:0] y0_q, y1_q;
	logic signed [63:0] prod_q, acc_q, l_q;
	logic signed [15:0] px_q, py_q;
	logic signed [31:0] vx_q, vy_q;
	logic [15:0] age_q, seen_q;
	logic [7:0] miss_q;
	rsp_t out_q;

	logic [TW-1:0] tidx;
	logic accept, out_free;
	logic [2:0] gi;
	logic [1:0] ur;
	logic [3:0] ce;
	logic [3:0] cov_idx;
	logic [2:0] g_idx;
	logic signed [31:0] cov_rd, g_rd;
	logic signed [33:0] mul_a, mul_b, m_val;
	logic signed [67:0] mul_full;
	logic signed [63:0] diff_sat, lval, upd_sum;
	logic signed [31:0] pred_cov [16];
	logic cov_we, rec_we;
	logic [TW+3:0] cov_addr;
	logic signed [31:0] cov_wdata;
	logic [31:0] cov_rdata;
	rec_t rec_rd, rec_eff, rec_wdata;
	logic div_start, div_busy, div_done;
	logic signed [DIV_W:0] div_quot;

	assign tidx = TW'(trk_q);
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !rsp_stall;
	assign gi = cnt_q[2:0];
	assign ur = cnt_q[1:0];
	assign ce = cnt_q[3:0];
	assign cov_rd = cov_q[cov_idx];
	assign g_rd = g_q[g_idx];
	assign mul_full = mul_a * mul_b;
	assign diff_sat = sat64(65'(acc_q) - 65'(prod_q));
	assign lval = trunc_unit(diff_sat) + HALF_S64;
	assign upd_sum = acc_q + prod_q;
	assign rec_eff = wr_q[tidx] ? rec_rd : '0;
	assign cov_addr = {tidx, cnt_q[3:0]};

	// Predicted covariance F P F' + Q, all entries at once from the loaded copy.
	always_comb begin
		logic signed [33:0] sum;
		logic signed [31:0] base;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sum = 34'(cov_q[r * 4 + c]);
				if (c < 2) sum = sum + 34'(cov_q[r * 4 + c + 2]);
				if (r < 2) sum = sum + 34'(cov_q[(r + 2) * 4 + c]);
				if (r < 2 && c < 2) sum = sum + 34'(cov_q[(r + 2) * 4 + c + 2]);
				base = c32(66'(sum));
				if (r == c) begin
					pred_cov[r * 4 + c] = c32(66'(base) + $signed({50'd0, pnoise_q}));
				end else begin
					pred_cov[r * 4 + c] = base;
				end
			end
		end
	end

	// Gain matrix entry of (I - K H) for row ce[3:2], column given by the phase.
	always_comb begin
		if (ce[3:2] == {1'b0, ph_q[1]}) begin
			m_val = UNIT_S34 - 34'(g_rd);
		end else begin
			m_val = -34'(g_rd);
		end
	end

	always_comb begin
		cov_idx = '0;
		g_idx = '0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		cov_we = 1'b0;
		cov_wdata = '0;
		case (state_q)
			ST_ZERO: begin
				cov_we = 1'b1;
			end
			ST_PWR: begin
				cov_we = 1'b1;
				cov_wdata = pred_cov[ce];
			end
			ST_DET: begin
				mul_a = (ph_q == 2'd0) ? s00_q : s01_q;
				mul_b = (ph_q == 2'd0) ? s11_q : s10_q;
			end
			ST_GAIN: begin
				case (ph_q)
					2'd0: begin
						cov_idx = {gi[2:1], 1'b0, gi[0]};
						mul_b = gi[0] ? s00_q : s11_q;
					end
					2'd1: begin
						cov_idx = {gi[2:1], 1'b0, ~gi[0]};
						mul_b = gi[0] ? s01_q : s10_q;
					end
					default: begin
						div_start = 1'b1;
					end
				endcase
				mul_a = 34'(cov_rd);
			end
			ST_UPD: begin
				g_idx = {ur, ph_q[0]};
				mul_a = 34'(g_rd);
				mul_b = (ph_q == 2'd0) ? 34'(y0_q) : 34'(y1_q);
			end
			ST_COV: begin
				case (ph_q)
					2'd0: cov_idx = ce;
					2'd1: begin
						cov_idx = {2'd0, ce[1:0]};
						g_idx = {ce[3:2], 1'b0};
					end
					2'd2: begin
						cov_idx = {2'd1, ce[1:0]};
						g_idx = {ce[3:2], 1'b1};
					end
					default: begin
						cov_we = 1'b1;
						cov_wdata = c32(66'(acc_q) + 66'(trunc_unit(prod_q)));
					end
				endcase
				mul_a = m_val;
				mul_b = 34'(cov_rd);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rec_wdata.pos_x = px_q;
		rec_wdata.pos_y = py_q;
		rec_wdata.vel_x = vx_q;
		rec_wdata.vel_y = vy_q;
		rec_wdata.age = age_q;
		rec_wdata.missed = miss_q;
		rec_wdata.seen = seen_q;
		rec_we = (state_q == ST_WB);
	end

	fptk_ram #(.WIDTH(32), .DEPTH(COV_DEPTH)) u_cov_ram (
		.clk(clk),
		.we(cov_we),
		.waddr(cov_addr),
		.wdata(cov_wdata),
		.raddr(cov_addr),
		.rdata(cov_rdata)
	);

	fptk_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_TRACKS)) u_rec_ram (
		.clk(clk),
		.we(rec_we),
		.waddr(tidx),
		.wdata(rec_wdata),
		.raddr(tidx),
		.rdata(rec_rd)
	);

	fptk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(diff_sat),
		.den(l_q),
		.busy(div_busy),
		.done(div_done),
		.quot(div_quot)
	);

	// Sequencer, track flags, registers and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ph_q <= '0;
			valid_q <= '0;
			wr_q <= '0;
			out_valid_q <= 1'b0;
			pnoise_q <= PNOISE_RST;
			mnoise_q <= MNOISE_RST;
			elim_q <= EXPIRE_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PNOISE: pnoise_q <= cfg_wdata;
					CFG_MNOISE: mnoise_q <= cfg_wdata;
					CFG_EXPIRE: elim_q <= cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						ph_q <= '0;
						if (int'(req_data.track) < NUM_TRACKS) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						cnt_q <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					ph_q <= '0;
					state_q <= ST_WB;
					if (func_q == FUNC_INIT) begin
						valid_q[tidx] <= 1'b1;
						wr_q[tidx] <= 1'b1;
						state_q <= ST_ZERO;
					end else if (func_q == FUNC_PREDICT && valid_q[tidx]) begin
						if (rec_eff.missed >= elim_q) begin
							valid_q[tidx] <= 1'b0;
						end else begin
							state_q <= ST_PWR;
						end
					end else if (func_q == FUNC_CORRECT && valid_q[tidx]) begin
						state_q <= ST_DET;
					end
				end
				ST_ZERO, ST_PWR: begin
					cnt_q <= cnt_q + 5'd1;
					if (ce == 4'd15) begin
						state_q <= ST_WB;
					end
				end
				ST_DET: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						cnt_q <= '0;
						state_q <= (lval == 64'sd0) ? ST_WB : ST_GAIN;
					end
				end
				ST_GAIN: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						cnt_q <= cnt_q + 5'd1;
						if (gi == 3'd7) begin
							cnt_q <= '0;
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_GAIN;
						end
					end
				end
				ST_UPD: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						cnt_q <= cnt_q + 5'd1;
						if (ur == 2'd3) begin
							cnt_q <= '0;
							state_q <= ST_COV;
						end
					end
				end
				ST_COV: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						cnt_q <= cnt_q + 5'd1;
						if (ce == 4'd15) begin
							state_q <= ST_WB;
						end
					end
				end
				ST_WB: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q <= req_data.func;
					trk_q <= req_data.track;
					mx_q <= req_data.meas_x;
					my_q <= req_data.meas_y;
					range_ok_q <= (int'(req_data.track) < NUM_TRACKS);
					expired_q <= 1'b0;
					singular_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				if (cnt_q != 5'd0) begin
					cov_q[4'(cnt_q - 5'd1)] <= $signed(cov_rdata);
				end
			end
			ST_EXEC: begin
				px_q <= rec_eff.pos_x;
				py_q <= rec_eff.pos_y;
				vx_q <= rec_eff.vel_x;
				vy_q <= rec_eff.vel_y;
				age_q <= rec_eff.age;
				miss_q <= rec_eff.missed;
				seen_q <= rec_eff.seen;
				if (func_q == FUNC_INIT) begin
					px_q <= mx_q;
					py_q <= my_q;
					vx_q <= '0;
					vy_q <= '0;
					age_q <= '0;
					miss_q <= '0;
					seen_q <= '0;
				end else if (func_q == FUNC_PREDICT && valid_q[tidx]) begin
					if (rec_eff.missed >= elim_q) begin
						expired_q <= 1'b1;
					end else begin
						px_q <= c16(34'(rec_eff.pos_x)
							+ 34'(trunc_unit(64'(rec_eff.vel_x) + HALF_S64)));
						py_q <= c16(34'(rec_eff.pos_y)
							+ 34'(trunc_unit(64'(rec_eff.vel_y) + HALF_S64)));
						if (rec_eff.age != 16'hFFFF) age_q <= rec_eff.age + 16'd1;
						if (rec_eff.missed != 8'hFF) miss_q <= rec_eff.missed + 8'd1;
					end
				end else if (func_q == FUNC_CORRECT && valid_q[tidx]) begin
					miss_q <= '0;
					if (rec_eff.seen != 16'hFFFF) seen_q <= rec_eff.seen + 16'd1;
					y0_q <= 17'(mx_q) - 17'(rec_eff.pos_x);
					y1_q <= 17'(my_q) - 17'(rec_eff.pos_y);
					s00_q <= 34'(cov_q[0]) + $signed({18'd0, mnoise_q});
					s01_q <= 34'(cov_q[1]) + $signed({18'd0, mnoise_q});
					s10_q <= 34'(cov_q[4]) + $signed({18'd0, mnoise_q});
					s11_q <= 34'(cov_q[5]) + $signed({18'd0, mnoise_q});
				end
			end
			ST_DET: begin
				if (ph_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (ph_q == 2'd2) begin
					l_q <= lval;
					if (lval == 64'sd0) singular_q <= 1'b1;
				end
			end
			ST_GAIN: begin
				if (ph_q == 2'd1) acc_q <= prod_q;
			end
			ST_DIVW: begin
				if (div_done) g_q[gi] <= c32(66'(div_quot));
			end
			ST_UPD: begin
				if (ph_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (ph_q == 2'd2) begin
					case (ur)
						2'd0: px_q <= c16(34'(px_q)
							+ 34'(clamp_step(trunc_unit(upd_sum + HALF_S64))));
						2'd1: py_q <= c16(34'(py_q)
							+ 34'(clamp_step(trunc_unit(upd_sum + HALF_S64))));
						2'd2: vx_q <= c32(66'(vx_q) + 66'(upd_sum));
						default: vy_q <= c32(66'(vy_q) + 66'(upd_sum));
					endcase
				end
			end
			ST_COV: begin
				if (ph_q == 2'd0) begin
					acc_q <= ce[3] ? 64'(cov_rd) : 64'sd0;
				end else if (ph_q == 2'd2) begin
					acc_q <= acc_q + trunc_unit(prod_q);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_q <= '0;
					if (range_ok_q) begin
						out_q.pos_x <= px_q;
						out_q.pos_y <= py_q;
						out_q.vel_x <= vx_q;
						out_q.vel_y <= vy_q;
						out_q.live <= valid_q[tidx];
						out_q.expired <= expired_q;
						out_q.singular <= singular_q;
						out_q.age_out <= age_q;
						out_q.missed_out <= miss_q;
						out_q.seen_out <= seen_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	a_expired_not_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.expired && rsp_data.live))
		else $error("expired track reported live");

	a_singular_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.singular |-> rsp_data.live && rsp_data.missed_out == 8'd0)
		else $error("singular update without a cleared missed count");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVW |-> div_busy || div_done)
		else $error("waiting on a divider that is not running");
endmodule
